[sv/lav_pkg.sv]
// shared types and a constant for the look-at view matrix block
package lav_pkg;

  localparam logic signed [31:0] FX_ONE = 32'sd65536;

  // one accepted item after the front has formed target - eye
  typedef struct packed {
    logic              fwd_zero;
    logic [2:0][32:0]  d;
    logic [2:0][31:0]  eye;
    logic [2:0][31:0]  up;
  } lav_item_t;

  // finished matrix handed from the back end to the column emitter
  typedef struct packed {
    logic              ident;
    logic [2:0][19:0]  rgt;
    logic [2:0][19:0]  cup;
    logic [2:0][19:0]  fwd;
    logic [2:0][31:0]  trans;
  } lav_mat_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MAG, B_SHIFT, B_MAC, B_POST, B_ROOT, B_DIV0, B_DIV, B_NDONE, B_DONE
  } back_state_t;

  typedef enum logic [1:0] {MD_SQ, MD_XUP, MD_XCUP, MD_DOT} mac_mode_t;

  typedef enum logic [1:0] {PH_FWD, PH_RGT1, PH_RGT2} phase_t;

  typedef struct packed {
    logic [1:0] a_comp;
    logic [1:0] b_comp;
    logic       neg;
    logic       first;
    logic [1:0] dst;
  } mac_term_t;

endpackage

[sv/lav_front.sv]
// input side: takes items, forms target - eye, flags a zero forward and queues them
module lav_front import lav_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,
  output logic         q_valid,
  output lav_item_t    q_item,
  input  logic         q_pop
);

  lav_item_t mem [2];
  logic      wr_ptr;
  logic      rd_ptr;
  logic [1:0] count;
  lav_item_t item_in;
  logic      push;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      item_in.eye[i] = s_tdata[32*i +: 32];
      item_in.up[i]  = s_tdata[192 + 32*i +: 32];
      item_in.d[i]   = 33'($signed(s_tdata[96 + 32*i +: 32])) -
                       33'($signed(s_tdata[32*i +: 32]));
    end
    item_in.fwd_zero = (item_in.d[0] == '0) && (item_in.d[1] == '0) && (item_in.d[2] == '0);
  end

  assign s_tready = (count != 2'd2);
  assign push     = s_tvalid && s_tready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

endmodule

[sv/lav_back.sv]
// back end: normalizes, crosses and dots with one shared multiplier, root and divide steps
module lav_back import lav_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_valid,
  input  lav_item_t q_item,
  output logic      q_pop,
  output logic      mat_valid,
  input  logic      mat_ready,
  output lav_mat_t  mat
);

  function automatic mac_term_t mac_term(input mac_mode_t mode, input logic [3:0] j);
    mac_term_t t;
    logic [1:0] p;
    logic [1:0] q;
    logic [1:0] g;
    logic [3:0] c;
    t = '0;
    g = (j >= 4'd6) ? 2'd2 : ((j >= 4'd3) ? 2'd1 : 2'd0);
    c = j - 4'(g) * 4'd3;
    p = (j[2:1] == 2'd2) ? 2'd0 : j[2:1] + 2'd1;
    q = (p == 2'd2) ? 2'd0 : p + 2'd1;
    case (mode)
      MD_SQ: begin
        t.a_comp = j[1:0];
        t.b_comp = j[1:0];
        t.first  = (j == 4'd0);
        t.dst    = 2'd0;
      end
      MD_DOT: begin
        t.a_comp = c[1:0];
        t.b_comp = c[1:0];
        t.first  = (c == 4'd0);
        t.dst    = g;
      end
      default: begin
        // cross products: a[p]*b[q] - a[q]*b[p]
        t.dst    = j[2:1];
        t.a_comp = j[0] ? q : p;
        t.b_comp = j[0] ? p : q;
        t.neg    = j[0];
        t.first  = ~j[0];
      end
    endcase
    return t;
  endfunction

  function automatic logic [3:0] mac_len(input mac_mode_t mode);
    case (mode)
      MD_SQ:   return 4'd3;
      MD_DOT:  return 4'd9;
      default: return 4'd6;
    endcase
  endfunction

  // round q32.32 to q16.16, ties away from zero
  function automatic logic signed [63:0] rnd16(input logic signed [63:0] v);
    logic [63:0] mg;
    logic [63:0] r;
    mg = v[63] ? 64'(-v) : 64'(v);
    r  = (mg + 64'd32768) >> 16;
    return v[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'h7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'h8000_0000;
    end
    return v[31:0];
  endfunction

  back_state_t state, state_next;
  phase_t      phase;
  mac_mode_t   mode;
  logic [3:0]  cnt;
  logic [1:0]  ci;
  logic [4:0]  step;

  logic signed [31:0] eye [3];
  logic signed [31:0] up [3];
  logic signed [51:0] vec [3];
  logic [51:0]        mag [3];
  logic [51:0]        m;
  logic [2:0]         sgn;
  logic signed [65:0] prod;
  logic signed [63:0] res [3];
  logic [62:0]        n;
  logic [62:0]        r;
  logic [62:0]        bitv;
  logic [31:0]        len;
  logic [47:0]        rem;
  logic [49:0]        dsr;
  logic [18:0]        q;
  logic signed [19:0] uvec [3];
  logic signed [19:0] fwd [3];
  logic signed [19:0] rgt [3];
  logic signed [19:0] cup [3];
  logic [31:0]        trans [3];
  logic               ident;

  logic [51:0]        mag_in [3];
  logic [51:0]        m_in;
  mac_term_t          tm, tp;
  logic signed [32:0] ma, mb;
  logic signed [63:0] acc_add;
  logic [63:0]        rt;
  logic               rge;
  logic [62:0]        r_next;
  logic               dge;
  logic [18:0]        q_next;
  logic               m_zero;
  logic               m_big;
  logic               m_small;

  // magnitudes and their maximum
  always_comb begin
    m_in = '0;
    for (int i = 0; i < 3; i++) begin
      mag_in[i] = vec[i][51] ? 52'(-vec[i]) : 52'(vec[i]);
      if (mag_in[i] > m_in) begin
        m_in = mag_in[i];
      end
    end
  end

  assign m_zero  = (m == '0);
  assign m_big   = (m[51:30] != '0);
  assign m_small = (m[51:29] == '0);

  // shared multiplier operand selection
  always_comb begin
    tm = mac_term(mode, cnt);
    tp = mac_term(mode, cnt - 4'd1);
    case (mode)
      MD_SQ: begin
        ma = $signed({3'b000, mag[tm.a_comp][29:0]});
        mb = $signed({3'b000, mag[tm.b_comp][29:0]});
      end
      MD_XUP: begin
        ma = 33'(fwd[tm.a_comp]);
        mb = 33'(up[tm.b_comp]);
      end
      MD_XCUP: begin
        ma = 33'(rgt[tm.a_comp]);
        mb = 33'(fwd[tm.b_comp]);
      end
      default: begin
        ma = (tm.dst == 2'd0) ? 33'(rgt[tm.a_comp]) :
             (tm.dst == 2'd1) ? 33'(cup[tm.a_comp]) : 33'(fwd[tm.a_comp]);
        mb = 33'(eye[tm.b_comp]);
      end
    endcase
    acc_add = tp.neg ? -prod[63:0] : prod[63:0];
  end

  // one square-root step and one divide step
  always_comb begin
    rt     = {1'b0, r} + {1'b0, bitv};
    rge    = ({1'b0, n} >= rt);
    r_next = rge ? (r >> 1) + bitv : (r >> 1);
    dge    = ({2'b00, rem} >= dsr);
    q_next = {q[17:0], dge};
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    case (state)
      B_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = q_item.fwd_zero ? B_DONE : B_MAG;
        end
      end
      B_MAG:   state_next = B_SHIFT;
      B_SHIFT: begin
        if (m_zero) begin
          state_next = (phase == PH_RGT1) ? B_MAG : B_DONE;
        end else if (!m_big && !m_small) begin
          state_next = B_MAC;
        end
      end
      B_MAC: begin
        if (cnt == mac_len(mode)) begin
          state_next = B_POST;
        end
      end
      B_POST: begin
        case (mode)
          MD_SQ:   state_next = B_ROOT;
          MD_XUP:  state_next = B_MAG;
          MD_XCUP: state_next = B_MAC;
          default: state_next = B_DONE;
        endcase
      end
      B_ROOT: begin
        if (bitv[0]) begin
          state_next = B_DIV0;
        end
      end
      B_DIV0: state_next = B_DIV;
      B_DIV: begin
        if (step == 5'd18) begin
          state_next = (ci == 2'd2) ? B_NDONE : B_DIV0;
        end
      end
      B_NDONE: state_next = B_MAC;
      B_DONE: begin
        if (mat_ready) begin
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      B_IDLE: begin
        ident <= q_item.fwd_zero;
        phase <= PH_FWD;
        for (int i = 0; i < 3; i++) begin
          eye[i] <= $signed(q_item.eye[i]);
          up[i]  <= $signed(q_item.up[i]);
          vec[i] <= 52'($signed(q_item.d[i]));
        end
      end
      B_MAG: begin
        m <= m_in;
        for (int i = 0; i < 3; i++) begin
          mag[i] <= mag_in[i];
          sgn[i] <= vec[i][51];
        end
      end
      B_SHIFT: begin
        if (m_zero) begin
          if (phase == PH_RGT1) begin
            // retry with up along z
            vec[0] <= 52'(fwd[1]) <<< 16;
            vec[1] <= -(52'(fwd[0]) <<< 16);
            vec[2] <= '0;
            phase  <= PH_RGT2;
          end else begin
            ident <= 1'b1;
          end
        end else if (m_big) begin
          m <= m >> 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] >> 1;
          end
        end else if (m_small) begin
          m <= m << 1;
          for (int i = 0; i < 3; i++) begin
            mag[i] <= mag[i] << 1;
          end
        end else begin
          mode <= MD_SQ;
          cnt  <= 4'd0;
        end
      end
      B_MAC: begin
        if (cnt != mac_len(mode)) begin
          prod <= ma * mb;
        end
        if (cnt != 4'd0) begin
          res[tp.dst] <= (tp.first ? 64'sd0 : res[tp.dst]) + acc_add;
        end
        cnt <= cnt + 4'd1;
      end
      B_POST: begin
        case (mode)
          MD_SQ: begin
            n    <= res[0][62:0];
            r    <= '0;
            bitv <= {1'b1, 62'd0};
          end
          MD_XUP: begin
            phase <= PH_RGT1;
            for (int i = 0; i < 3; i++) begin
              vec[i] <= res[i][51:0];
            end
          end
          MD_XCUP: begin
            for (int i = 0; i < 3; i++) begin
              cup[i] <= 20'(rnd16(res[i]));
            end
            mode <= MD_DOT;
            cnt  <= 4'd0;
          end
          default: begin
            trans[0] <= sat32(-rnd16(res[0]));
            trans[1] <= sat32(-rnd16(res[1]));
            trans[2] <= sat32(rnd16(res[2]));
          end
        endcase
      end
      B_ROOT: begin
        if (rge) begin
          n <= n - rt[62:0];
        end
        r    <= r_next;
        bitv <= bitv >> 2;
        if (bitv[0]) begin
          len <= r_next[31:0];
          ci  <= 2'd0;
        end
      end
      B_DIV0: begin
        rem  <= {2'b00, mag[ci][29:0], 16'd0} + {17'd0, len[31:1]};
        dsr  <= {len, 18'd0};
        q    <= '0;
        step <= 5'd0;
      end
      B_DIV: begin
        if (dge) begin
          rem <= rem - dsr[47:0];
        end
        q    <= q_next;
        dsr  <= dsr >> 1;
        step <= step + 5'd1;
        if (step == 5'd18) begin
          uvec[ci] <= sgn[ci] ? -$signed({1'b0, q_next}) : $signed({1'b0, q_next});
          ci       <= ci + 2'd1;
        end
      end
      B_NDONE: begin
        cnt <= 4'd0;
        if (phase == PH_FWD) begin
          mode <= MD_XUP;
          for (int i = 0; i < 3; i++) begin
            fwd[i] <= uvec[i];
          end
        end else begin
          mode <= MD_XCUP;
          for (int i = 0; i < 3; i++) begin
            rgt[i] <= uvec[i];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign mat_valid = (state == B_DONE);

  always_comb begin
    mat.ident = ident;
    for (int i = 0; i < 3; i++) begin
      mat.rgt[i]   = rgt[i];
      mat.cup[i]   = cup[i];
      mat.fwd[i]   = fwd[i];
      mat.trans[i] = trans[i];
    end
  end

endmodule

[sv/lav_emit.sv]
// output side: holds one matrix and sends it as four column transfers
module lav_emit import lav_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         mat_valid,
  output logic         mat_ready,
  input  lav_mat_t     mat,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,
  output logic         m_tlast,
  output logic         m_tuser
);

  lav_mat_t   cur;
  logic       busy;
  logic [1:0] col;
  logic [31:0] e [4];
  logic       fire;

  assign fire      = m_tvalid && m_tready;
  assign mat_ready = !busy || (fire && col == 2'd3);
  assign m_tvalid  = busy;
  assign m_tlast   = (col == 2'd3);
  assign m_tuser   = cur.ident;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      e[i] = '0;
    end
    if (cur.ident) begin
      e[col] = FX_ONE;
    end else if (col == 2'd3) begin
      e[0] = cur.trans[0];
      e[1] = cur.trans[1];
      e[2] = cur.trans[2];
      e[3] = FX_ONE;
    end else begin
      e[0] = 32'($signed(cur.rgt[col]));
      e[1] = 32'($signed(cur.cup[col]));
      e[2] = -32'($signed(cur.fwd[col]));
    end
    m_tdata = {6'd0, e[3], e[2], e[1], e[0], col};
  end

  always_ff @(posedge clk) begin
    if (mat_valid && mat_ready) begin
      cur <= mat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      col  <= 2'd0;
    end else if (mat_valid && mat_ready) begin
      busy <= 1'b1;
      col  <= 2'd0;
    end else if (fire) begin
      col <= col + 2'd1;
      if (col == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[sv/look_at_view_matrix.sv]
// top level of the right-handed look-at view matrix builder
//
//   channel  dir  width  contents
//   s_       in   288    eye xyz, target xyz, up xyz (signed q16.16)
//   m_       out  136    column_index, entry_0..entry_3; tlast last column, tuser identity
//
// in the back end, forward and right are each normalized by one-bit shifts, a 32-step
// square root and three 19-step divides, and the cross and dot passes share one multiplier;
// a zero forward vector goes straight to the identity result.
// the front queue holds two items so input transfers go on while the back end works,
// and a finished matrix waits in the emitter while the next one is computed.
// rst is synchronous and empties the queue, the sequencer and the emitter.
module look_at_view_matrix import lav_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [287:0] s_tdata,   // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [135:0] m_tdata,   // column_index, entry_0, entry_1, entry_2, entry_3, zero pad
  output logic         m_tlast,
  output logic         m_tuser    // identity_fallback
);

  logic      q_valid;
  logic      q_pop;
  lav_item_t q_item;
  logic      mat_valid;
  logic      mat_ready;
  lav_mat_t  mat;

  lav_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  lav_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat)
  );

  lav_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat       (mat),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

[bench/look_at_view_matrix_test.sv]
// testbench for the look-at view matrix builder: directed and random camera setups checked column by column
`timescale 1ns / 100ps

module look_at_view_matrix_test;
  import lav_pkg::*;

  typedef struct packed {
    logic [1:0]       col;
    logic [3:0][31:0] entry;
    logic             last;
    logic             ident;
  } column_t;

  localparam longint CYCLE_LIMIT = 3000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [287:0] s_tdata;
  logic         m_tvalid;
  logic         m_tready;
  logic [135:0] m_tdata;
  logic         m_tlast;
  logic         m_tuser;

  column_t      column_queue[$];
  int           mismatches;
  int           send_idle;
  int           recv_idle;
  bit           recv_hold;
  longint       cycles;

  look_at_view_matrix u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------- matrix predictor ----------------

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned r;
    longint unsigned bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    return r;
  endfunction

  function automatic longint round_q16(input longint v);
    longint unsigned mg;
    longint r;
    mg = (v < 0) ? longint'(-v) : v;
    r = longint'((mg + 64'd32768) >> 16);
    return (v < 0) ? -r : r;
  endfunction

  function automatic longint clip32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic bit to_unit(input longint d[3], output longint u[3]);
    longint unsigned mg[3];
    longint unsigned mx;
    longint unsigned sq;
    longint unsigned len;
    longint q;
    mx = 0;
    sq = 0;
    for (int i = 0; i < 3; i++) begin
      mg[i] = (d[i] < 0) ? longint'(-d[i]) : d[i];
      if (mg[i] > mx) mx = mg[i];
    end
    u = '{0, 0, 0};
    if (mx == 0) return 1'b0;
    while (mx >= (64'd1 << 30)) begin
      for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
      mx = mx >> 1;
    end
    while (mx < (64'd1 << 29)) begin
      for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
      mx = mx << 1;
    end
    for (int i = 0; i < 3; i++) sq = sq + mg[i] * mg[i];
    len = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = longint'(((mg[i] << 16) + (len >> 1)) / len);
      u[i] = (d[i] < 0) ? -q : q;
    end
    return 1'b1;
  endfunction

  function automatic void cross3(input longint a[3], input longint b[3], output longint o[3]);
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic void predict_matrix(input logic [31:0] w[9]);
    longint eye[3], up[3], d[3], fwd[3], rgt[3], cup[3], raw[3], zup[3];
    longint m[16];
    bit ident;
    column_t c;
    zup = '{0, 0, 65536};
    for (int i = 0; i < 3; i++) begin
      eye[i] = longint'($signed(w[i]));
      d[i] = longint'($signed(w[3 + i])) - eye[i];
      up[i] = longint'($signed(w[6 + i]));
    end
    ident = 1'b0;
    if (!to_unit(d, fwd)) begin
      ident = 1'b1;
    end else begin
      cross3(fwd, up, raw);
      if (!to_unit(raw, rgt)) begin
        // up parallel to forward, retry with z up
        cross3(fwd, zup, raw);
        if (!to_unit(raw, rgt)) ident = 1'b1;
      end
    end
    if (ident) begin
      for (int i = 0; i < 16; i++) m[i] = (i % 5 == 0) ? 65536 : 0;
    end else begin
      cross3(rgt, fwd, raw);
      for (int i = 0; i < 3; i++) cup[i] = round_q16(raw[i]);
      for (int i = 0; i < 3; i++) begin
        m[4 * i + 0] = rgt[i];
        m[4 * i + 1] = cup[i];
        m[4 * i + 2] = -fwd[i];
        m[4 * i + 3] = 0;
      end
      m[12] = clip32(-round_q16(rgt[0] * eye[0] + rgt[1] * eye[1] + rgt[2] * eye[2]));
      m[13] = clip32(-round_q16(cup[0] * eye[0] + cup[1] * eye[1] + cup[2] * eye[2]));
      m[14] = clip32(round_q16(fwd[0] * eye[0] + fwd[1] * eye[1] + fwd[2] * eye[2]));
      m[15] = 65536;
    end
    for (int col = 0; col < 4; col++) begin
      c.col = col[1:0];
      for (int i = 0; i < 4; i++) c.entry[i] = m[4 * col + i][31:0];
      c.last = (col == 3);
      c.ident = ident;
      column_queue.push_back(c);
    end
  endfunction

  // ---------------- stimulus side ----------------

  task automatic send_item(input logic [31:0] w[9]);
    bit hs;
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    for (int i = 0; i < 9; i++) s_tdata[32 * i +: 32] <= w[i];
    hs = 1'b0;
    while (!hs) begin
      @(negedge clk);
      hs = s_tready;
      @(posedge clk);
    end
    predict_matrix(w);
  endtask

  task automatic rest_idle();
    s_tvalid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] coord(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'($signed($urandom_range(13107200)) - 32'sd6553600);  // within +-100.0
      default: return 32'($signed($urandom_range(1024)) - 32'sd512);    // tiny
    endcase
  endfunction

  task automatic send_random();
    logic [31:0] w[9];
    int mode;
    int kind;
    mode = $urandom_range(2);
    for (int i = 0; i < 9; i++) w[i] = coord(mode);
    kind = $urandom_range(19);
    if (kind == 0) begin
      for (int i = 0; i < 3; i++) w[3 + i] = w[i];          // target on the eye
    end else if (kind == 1) begin
      for (int i = 0; i < 3; i++) w[6 + i] = w[3 + i] - w[i];  // up along forward
    end else if (kind == 2) begin
      w[3] = w[0];
      w[4] = w[1];                                           // looking along z
      w[6] = 0; w[7] = 0;
    end else if (kind == 3) begin
      for (int i = 0; i < 3; i++) w[6 + i] = 0;              // zero up
    end
    send_item(w);
  endtask

  // ---------------- result side ----------------

  always @(posedge clk) begin
    if (rst || recv_hold) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  always @(negedge clk) begin
    column_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.col = m_tdata[1:0];
      for (int i = 0; i < 4; i++) got.entry[i] = m_tdata[2 + 32 * i +: 32];
      got.last = m_tlast;
      got.ident = m_tuser;
      if (column_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected column transfer %h", got);
      end else begin
        want = column_queue.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("column mismatch: expected col %0d %h %h %h %h last %b id %b, got col %0d %h %h %h %h last %b id %b",
                     want.col, want.entry[0], want.entry[1], want.entry[2], want.entry[3],
                     want.last, want.ident, got.col, got.entry[0], got.entry[1],
                     got.entry[2], got.entry[3], got.last, got.ident);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---------------- tests ----------------

  task automatic test_directed();
    logic [31:0] mn, mx;
    mn = 32'h8000_0000;
    mx = 32'h7fff_ffff;
    // target on the eye
    send_item('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0});
    send_item('{mx, mn, mx, mx, mn, mx, mx, mx, mx});
    // plain camera at +y, slightly above, looking at the origin with z up
    send_item('{32'd0, 32'd327680, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536});
    // up parallel to forward, retry succeeds
    send_item('{32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd131072, 32'd0, 32'd0});
    // zero up, retry succeeds
    send_item('{32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd0, 32'd0});
    // forward along z, both attempts zero
    send_item('{32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 32'd0, 32'd0, 32'd65536});
    send_item('{32'd0, 32'd0, mx, 32'd0, 32'd0, mn, 32'd0, 32'd0, mn});
    // widest differences
    send_item('{mn, mn, mn, mx, mx, mx, mx, mn, mx});
    send_item('{mx, mx, mx, mn, mn, mn, mn, mx, mn});
    // translation saturates
    send_item('{mn, mn, mn, mn + 32'd65536, mn + 32'd65536, mn + 32'd65536,
                32'd0, 32'd0, 32'd65536});
    send_item('{mx, mx, mx, mx - 32'd65536, mx - 32'd65536, mx - 32'd65536,
                32'd0, 32'd0, 32'd65536});
    send_item('{mn, mx, mn, mn, mx - 32'd1, mn, mx, 32'd0, mn});
    // smallest steps
    send_item('{32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0});
    send_item('{32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd1, 32'hffff_ffff,
                32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff});
    send_item('{32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa,
                32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555, 32'haaaa_aaaa, 32'h5555_5555});
    rest_idle();
  endtask

  task automatic test_random_phase(input int sidle, input int ridle, input int count);
    send_idle = sidle;
    recv_idle = ridle;
    for (int n = 0; n < count; n++) send_random();
    rest_idle();
  endtask

  task automatic test_backpressure();
    send_idle = 0;
    recv_idle = 0;
    recv_hold = 1'b1;
    fork
      begin
        repeat (4000) @(posedge clk);
        recv_hold = 1'b0;
      end
      for (int n = 0; n < 8; n++) send_random();
    join
    rest_idle();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    m_tready = 1'b0;
    mismatches = 0;
    send_idle = 22;
    recv_idle = 63;
    recv_hold = 1'b0;
    cycles = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed();
    test_random_phase(22, 63, 75);
    test_random_phase(63, 22, 75);
    test_backpressure();
    test_random_phase(0, 0, 75);

    wait (column_queue.size() == 0);
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && column_queue.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
sv/lav_pkg.sv
sv/lav_front.sv
sv/lav_back.sv
sv/lav_emit.sv
sv/look_at_view_matrix.sv
bench/look_at_view_matrix_test.sv
